// ===== hdl/tfp_pkg.sv =====
// Package for the triangle facet properties unit: beat structs, field widths
// and arithmetic constants. No dependencies; imported by the top level.
package tfp_pkg;

    // Field widths of the beats
    localparam int VTX_W  = 24;   // Q12.12 vertex coordinate
    localparam int AREA_W = 41;   // area, 12 fractional bits
    localparam int NORM_W = 16;   // Q1.14 normal component
    localparam int TAG_W  = 16;   // material tag

    // Edge vectors and cross product
    localparam int EDGE_W = VTX_W + 1;       // difference of two vertices
    localparam int PROD_W = 2 * EDGE_W;      // one cross product term
    localparam int NRM_W  = PROD_W + 1;      // signed cross product component
    localparam int MAG_W  = NRM_W;           // its magnitude

    // Squares of the cross product, split into two halves per operand
    localparam int LO_W   = 25;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int HH_W   = 2 * HI_W;
    localparam int HL_W   = HI_W + LO_W;
    localparam int LL_W   = 2 * LO_W;
    localparam int SQ_W   = 2 * MAG_W;       // sum of three squares fits

    // Square root: one result bit per stage
    localparam int RT_W   = 52;
    localparam int RAD_W  = 2 * RT_W;
    localparam int REM_W  = RT_W + 2;

    // Normal division: one quotient bit per stage
    localparam int FRAC_N = 14;
    localparam int QT_W   = FRAC_N + 1;
    localparam int DIV_W  = MAG_W + QT_W;
    localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1 << FRAC_N);

    // Area is half the length with 12 fractional bits
    localparam int AREA_SHIFT = 13;

    // Centroid: divide the vertex sum by three through a reciprocal
    localparam int CSUM_W  = VTX_W + 2;
    localparam int CMAG_W  = CSUM_W - 1;
    localparam int CPROD_W = 2 * CMAG_W;
    localparam int CSHIFT  = CMAG_W + 1;
    localparam logic [CMAG_W-1:0] C3_RECIP = CMAG_W'(((64'd1 << CSHIFT) + 64'd2) / 64'd3);

    typedef struct packed {
        logic signed [VTX_W-1:0] vertex0_x;
        logic signed [VTX_W-1:0] vertex0_y;
        logic signed [VTX_W-1:0] vertex0_z;
        logic signed [VTX_W-1:0] vertex1_x;
        logic signed [VTX_W-1:0] vertex1_y;
        logic signed [VTX_W-1:0] vertex1_z;
        logic signed [VTX_W-1:0] vertex2_x;
        logic signed [VTX_W-1:0] vertex2_y;
        logic signed [VTX_W-1:0] vertex2_z;
    } t_facet_in;

    typedef struct packed {
        logic [AREA_W-1:0]        facet_area;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic signed [VTX_W-1:0]  centroid_x;
        logic signed [VTX_W-1:0]  centroid_y;
        logic signed [VTX_W-1:0]  centroid_z;
        logic [TAG_W-1:0]         material_out;
        logic                     degenerate;
    } t_facet_out;

    // Side data carried along the square root stages
    typedef struct packed {
        logic [2:0]             nneg;
        logic [2:0][MAG_W-1:0]  nmag;
        logic [2:0][VTX_W-1:0]  cent;
    } t_side;

    // Side data carried along the division stages
    typedef struct packed {
        logic [2:0]             nneg;
        logic [RT_W-1:0]        len;
        logic [2:0][VTX_W-1:0]  cent;
    } t_dside;

endpackage

// ===== hdl/triangle_facet_properties_unit.sv =====
// Top level of the triangle facet properties unit: full pipeline from
// vertices to area, unit normal, centroid and tag. Depends on tfp_pkg.
//
//  channel   direction  handshake                    payload
//  in        to unit    i_in_valid / o_in_ready      i_in  (t_facet_in)
//  out       from unit  o_out_valid / i_out_ready    o_out (t_facet_out)
//  cfg       to unit    i_cfg_we                     i_cfg_wdata (material tag)
//
// One triangle a cycle while the output is taken: 5 stages of edges, products
// and squares, 1 sum stage, 52 square root stages (one root bit each) and 15
// division stages (one normal bit each, three lanes side by side).
// All stages advance together; the last stage is the output register and
// the whole pipe holds while it carries a beat that is not taken.
// Synchronous active-low reset clears the valid bits and the tag.
module triangle_facet_properties_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tfp_pkg::t_facet_in        i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tfp_pkg::t_facet_out       o_out,
    input  logic                      i_cfg_we,
    input  logic [tfp_pkg::TAG_W-1:0] i_cfg_wdata
);
    import tfp_pkg::*;

    logic w_en;
    logic [TAG_W-1:0] r_material_tag;
    logic signed [VTX_W-1:0] w_v [9];

    // Stage registers
    logic                      r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [EDGE_W-1:0]  r_e1 [3];
    logic signed [EDGE_W-1:0]  r_e2 [3];
    logic signed [CSUM_W-1:0]  r_csum [3];
    logic signed [PROD_W-1:0]  r_p [6];
    logic [CPROD_W-1:0]        r_cprod [3];
    logic [2:0]                r_cneg;
    logic [CMAG_W-1:0]         w_cmag [3];
    logic signed [NRM_W-1:0]   w_n [3];
    t_side                     n_side3, r_side3, r_side4, r_side5;
    logic [HH_W-1:0]           r_hh [3];
    logic [HL_W-1:0]           r_hl [3];
    logic [LL_W-1:0]           r_ll [3];
    logic [SQ_W-1:0]           r_sq [3];

    // Square root stages; index 0 is the sum stage
    logic                      r_qv    [RT_W+1];
    logic [RAD_W-1:0]          r_rad   [RT_W+1];
    logic [REM_W-1:0]          r_rem   [RT_W+1];
    logic [RT_W-1:0]           r_root  [RT_W+1];
    t_side                     r_qside [RT_W+1];

    // Division stages
    logic                      r_dv    [QT_W];
    logic [DIV_W-1:0]          r_drem  [QT_W][3];
    logic [QT_W-1:0]           r_q     [QT_W][3];
    t_dside                    r_dside [QT_W];

    // Advance the whole pipe unless the output beat is stalled
    assign w_en        = !r_dv[QT_W-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_dv[QT_W-1];

    // Hold the material tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_material_tag <= '0;
        end else if (i_cfg_we) begin
            r_material_tag <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_v[0] = i_in.vertex0_x;
        w_v[1] = i_in.vertex0_y;
        w_v[2] = i_in.vertex0_z;
        w_v[3] = i_in.vertex1_x;
        w_v[4] = i_in.vertex1_y;
        w_v[5] = i_in.vertex1_z;
        w_v[6] = i_in.vertex2_x;
        w_v[7] = i_in.vertex2_y;
        w_v[8] = i_in.vertex2_z;
    end

    // Valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage 1: edge vectors and vertex sums
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i]   <= EDGE_W'(w_v[3+i]) - EDGE_W'(w_v[i]);
                r_e2[i]   <= EDGE_W'(w_v[6+i]) - EDGE_W'(w_v[i]);
                r_csum[i] <= CSUM_W'(w_v[i]) + CSUM_W'(w_v[3+i]) + CSUM_W'(w_v[6+i]);
            end
        end
    end

    // Stage 2: cross product terms and centroid reciprocal products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cmag[i] = r_csum[i][CSUM_W-1] ? CMAG_W'(-r_csum[i]) : CMAG_W'(r_csum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            for (int i = 0; i < 3; i++) begin
                r_cprod[i] <= w_cmag[i] * C3_RECIP;
                r_cneg[i]  <= r_csum[i][CSUM_W-1];
            end
        end
    end

    // Stage 3: cross product components as sign and magnitude, centroid
    always_comb begin
        logic [VTX_W-1:0] q;
        w_n[0] = NRM_W'(r_p[0]) - NRM_W'(r_p[1]);
        w_n[1] = NRM_W'(r_p[2]) - NRM_W'(r_p[3]);
        w_n[2] = NRM_W'(r_p[4]) - NRM_W'(r_p[5]);
        for (int i = 0; i < 3; i++) begin
            n_side3.nneg[i] = w_n[i][NRM_W-1];
            n_side3.nmag[i] = w_n[i][NRM_W-1] ? MAG_W'(-w_n[i]) : MAG_W'(w_n[i]);
            q = r_cprod[i][CSHIFT+VTX_W-1:CSHIFT];
            n_side3.cent[i] = r_cneg[i] ? VTX_W'(-q) : q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side3 <= n_side3;
        end
    end

    // Stage 4: partial products of each square
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side4 <= r_side3;
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= r_side3.nmag[i][MAG_W-1:LO_W] * r_side3.nmag[i][MAG_W-1:LO_W];
                r_hl[i] <= r_side3.nmag[i][MAG_W-1:LO_W] * r_side3.nmag[i][LO_W-1:0];
                r_ll[i] <= r_side3.nmag[i][LO_W-1:0] * r_side3.nmag[i][LO_W-1:0];
            end
        end
    end

    // Stage 5: assemble each square
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side5 <= r_side4;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (SQ_W'(r_hh[i]) << (2 * LO_W))
                         + (SQ_W'(r_hl[i]) << (LO_W + 1))
                         + SQ_W'(r_ll[i]);
            end
        end
    end

    // Stage 6: sum of squares enters the root pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv[0] <= 1'b0;
        end else if (w_en) begin
            r_qv[0] <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad[0]   <= RAD_W'(r_sq[0] + r_sq[1] + r_sq[2]);
            r_rem[0]   <= '0;
            r_root[0]  <= '0;
            r_qside[0] <= r_side5;
        end
    end

    // Square root: bring down two radicand bits, try the next root bit
    for (genvar k = 1; k <= RT_W; k++) begin : g_sqrt
        logic [REM_W-1:0] w_rem2;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;

        assign w_rem2  = {r_rem[k-1][REM_W-3:0], r_rad[k-1][RAD_W-1 -: 2]};
        assign w_trial = {r_root[k-1], 2'b01};
        assign w_ge    = w_rem2 >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[k] <= 1'b0;
            end else if (w_en) begin
                r_qv[k] <= r_qv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rad[k]   <= r_rad[k-1] << 2;
                r_rem[k]   <= w_ge ? w_rem2 - w_trial : w_rem2;
                r_root[k]  <= {r_root[k-1][RT_W-2:0], w_ge};
                r_qside[k] <= r_qside[k-1];
            end
        end
    end

    // Division: one quotient bit per stage for all three normal lanes
    for (genvar j = 0; j < QT_W; j++) begin : g_div
        logic             w_v_in;
        logic [DIV_W-1:0] w_rem_in [3];
        logic [QT_W-1:0]  w_q_in   [3];
        t_dside           w_side_in;
        logic [DIV_W-1:0] w_dsh;

        if (j == 0) begin : g_first
            assign w_v_in         = r_qv[RT_W];
            assign w_side_in.nneg = r_qside[RT_W].nneg;
            assign w_side_in.len  = r_root[RT_W];
            assign w_side_in.cent = r_qside[RT_W].cent;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign w_rem_in[i] = DIV_W'(r_qside[RT_W].nmag[i]) << FRAC_N;
                assign w_q_in[i]   = '0;
            end
        end else begin : g_next
            assign w_v_in    = r_dv[j-1];
            assign w_side_in = r_dside[j-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign w_rem_in[i] = r_drem[j-1][i];
                assign w_q_in[i]   = r_q[j-1][i];
            end
        end

        assign w_dsh = DIV_W'(w_side_in.len) << (QT_W - 1 - j);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else if (w_en) begin
                r_dv[j] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dside[j] <= w_side_in;
                for (int i = 0; i < 3; i++) begin
                    if (w_rem_in[i] >= w_dsh) begin
                        r_drem[j][i] <= w_rem_in[i] - w_dsh;
                        r_q[j][i]    <= {w_q_in[i][QT_W-2:0], 1'b1};
                    end else begin
                        r_drem[j][i] <= w_rem_in[i];
                        r_q[j][i]    <= {w_q_in[i][QT_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Output beat from the last division stage
    always_comb begin
        logic                     deg;
        logic signed [NORM_W-1:0] nrm [3];
        deg = r_dside[QT_W-1].len == '0;
        for (int i = 0; i < 3; i++) begin
            nrm[i] = r_dside[QT_W-1].nneg[i] ? -NORM_W'(r_q[QT_W-1][i])
                                             : NORM_W'(r_q[QT_W-1][i]);
        end
        o_out.facet_area   = AREA_W'(r_dside[QT_W-1].len >> AREA_SHIFT);
        o_out.normal_x     = deg ? '0 : nrm[0];
        o_out.normal_y     = deg ? '0 : nrm[1];
        o_out.normal_z     = deg ? NORM_ONE : nrm[2];
        o_out.centroid_x   = r_dside[QT_W-1].cent[0];
        o_out.centroid_y   = r_dside[QT_W-1].cent[1];
        o_out.centroid_z   = r_dside[QT_W-1].cent[2];
        o_out.material_out = r_material_tag;
        o_out.degenerate   = deg;
    end

endmodule

// ===== tb/triangle_facet_properties_unit_tb.sv =====
// Self-checking testbench for triangle_facet_properties_unit: directed triangles
// then random ones, checked against a bit-exact facet model. Depends on tfp_pkg.
module triangle_facet_properties_unit_tb;
    import tfp_pkg::*;

    localparam int LATENCY   = 73;
    localparam int N_RANDOM  = 1930;
    localparam int N_PHASES  = 4;
    localparam int CYCLE_CAP = 400000;

    typedef struct {
        t_facet_in  tri_in;
        bit         typed;
        t_facet_out want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_facet_in        i_in = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_facet_out       o_out;
    logic             i_cfg_we = 1'b0;
    logic [TAG_W-1:0] i_cfg_wdata = '0;

    t_facet_out       facet_queue[$];
    logic [TAG_W-1:0] tag_now = '0;
    int               mismatches = 0;
    int               cycles = 0;
    bit               quiet = 1'b0;
    t_row             rows[$];

    triangle_facet_properties_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Append one expected facet at the tail of the scoreboard
    function automatic void queue_facet(t_facet_out w);
        facet_queue.insert(facet_queue.size(), w);
    endfunction

    // Append one stimulus row at the end of the table
    function automatic void stash_row(t_row r);
        rows.insert(rows.size(), r);
    endfunction

    // Area, unit normal and centroid of one triangle
    function automatic t_facet_out facet_props(t_facet_in f, logic [TAG_W-1:0] tag);
        logic signed [63:0] v[9];
        logic signed [63:0] e1[3], e2[3], n[3], s;
        logic [127:0] sq, c2;
        logic [63:0]  len, cand, m;
        logic [79:0]  q;
        t_facet_out   r;
        v[0] = f.vertex0_x; v[1] = f.vertex0_y; v[2] = f.vertex0_z;
        v[3] = f.vertex1_x; v[4] = f.vertex1_y; v[5] = f.vertex1_z;
        v[6] = f.vertex2_x; v[7] = f.vertex2_y; v[8] = f.vertex2_z;
        for (int i = 0; i < 3; i++) begin
            e1[i] = v[3+i] - v[i];
            e2[i] = v[6+i] - v[i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            m = (n[i] < 0) ? -n[i] : n[i];
            sq += {64'b0, m} * {64'b0, m};
        end
        // floor square root, one bit at a time
        len = '0;
        for (int b = 51; b >= 0; b--) begin
            cand = len | (64'd1 << b);
            c2 = {64'b0, cand} * {64'b0, cand};
            if (c2 <= sq) len = cand;
        end
        r = '0;
        r.facet_area = AREA_W'(len >> AREA_SHIFT);
        if (len == 0) begin
            r.normal_z   = NORM_ONE;
            r.degenerate = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                m = (n[i] < 0) ? -n[i] : n[i];
                q = ({16'b0, m} << FRAC_N) / {16'b0, len};
                if (i == 0) r.normal_x = (n[i] < 0) ? -q[15:0] : q[15:0];
                if (i == 1) r.normal_y = (n[i] < 0) ? -q[15:0] : q[15:0];
                if (i == 2) r.normal_z = (n[i] < 0) ? -q[15:0] : q[15:0];
            end
        end
        s = (v[0] + v[3] + v[6]) / 3; r.centroid_x = s[VTX_W-1:0];
        s = (v[1] + v[4] + v[7]) / 3; r.centroid_y = s[VTX_W-1:0];
        s = (v[2] + v[5] + v[8]) / 3; r.centroid_z = s[VTX_W-1:0];
        r.material_out = tag;
        return r;
    endfunction

    function automatic logic [VTX_W-1:0] near(int span);
        return VTX_W'($urandom_range(0, 2 * span) - span);
    endfunction

    // Mostly mesh-like triangles, some full-range noise, some degenerate
    function automatic t_facet_in random_facet();
        t_facet_in  f;
        int         pick, k;
        logic signed [VTX_W-1:0] d[3], b[3];
        pick = $urandom_range(0, 99);
        f = '0;
        if (pick < 30) begin
            f.vertex0_x = VTX_W'($urandom()); f.vertex0_y = VTX_W'($urandom());
            f.vertex0_z = VTX_W'($urandom()); f.vertex1_x = VTX_W'($urandom());
            f.vertex1_y = VTX_W'($urandom()); f.vertex1_z = VTX_W'($urandom());
            f.vertex2_x = VTX_W'($urandom()); f.vertex2_y = VTX_W'($urandom());
            f.vertex2_z = VTX_W'($urandom());
        end else if (pick < 85) begin
            b[0] = VTX_W'($urandom()); b[1] = VTX_W'($urandom()); b[2] = VTX_W'($urandom());
            f.vertex0_x = b[0]; f.vertex0_y = b[1]; f.vertex0_z = b[2];
            f.vertex1_x = b[0] + near(40000); f.vertex1_y = b[1] + near(40000);
            f.vertex1_z = b[2] + near(40000);
            f.vertex2_x = b[0] + near(40000); f.vertex2_y = b[1] + near(40000);
            f.vertex2_z = b[2] + near(40000);
        end else begin
            // collinear or repeated vertices
            b[0] = near(1000000); b[1] = near(1000000); b[2] = near(1000000);
            d[0] = near(3000); d[1] = near(3000); d[2] = near(3000);
            k = $urandom_range(0, 3);
            f.vertex0_x = b[0]; f.vertex0_y = b[1]; f.vertex0_z = b[2];
            f.vertex1_x = b[0] + d[0]; f.vertex1_y = b[1] + d[1]; f.vertex1_z = b[2] + d[2];
            f.vertex2_x = VTX_W'(b[0] + k * d[0]); f.vertex2_y = VTX_W'(b[1] + k * d[1]);
            f.vertex2_z = VTX_W'(b[2] + k * d[2]);
        end
        return f;
    endfunction

    function automatic t_facet_in tri9(int a0, int a1, int a2, int b0, int b1, int b2,
                                       int c0, int c1, int c2);
        t_facet_in f;
        f.vertex0_x = VTX_W'(a0); f.vertex0_y = VTX_W'(a1); f.vertex0_z = VTX_W'(a2);
        f.vertex1_x = VTX_W'(b0); f.vertex1_y = VTX_W'(b1); f.vertex1_z = VTX_W'(b2);
        f.vertex2_x = VTX_W'(c0); f.vertex2_y = VTX_W'(c1); f.vertex2_z = VTX_W'(c2);
        return f;
    endfunction

    function automatic t_facet_out flat(int area, int nz, int cx, int cy, int cz, bit dg);
        t_facet_out r;
        r = '0;
        r.facet_area = AREA_W'(area); r.normal_z = NORM_W'(nz);
        r.centroid_x = VTX_W'(cx); r.centroid_y = VTX_W'(cy); r.centroid_z = VTX_W'(cz);
        r.degenerate = dg;
        return r;
    endfunction

    // Hand off one triangle and record its expected facet
    task automatic send(t_facet_in f, bit typed, t_facet_out want, bit last);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 19) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= f;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        queue_facet(typed ? want : facet_props(f, tag_now));
        @(negedge i_clk);
        if (last) i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (facet_queue.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Receiver stall pattern
    always @(negedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(0, 99) >= 19);
    end

    // Compare each output beat against the oldest expectation
    always @(posedge i_clk) begin
        t_facet_out w;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (facet_queue.size() == 0) begin
                $error("unexpected beat: %p", o_out);
                mismatches++;
            end else begin
                w = facet_queue.pop_front();
                if (o_out.facet_area !== w.facet_area) begin
                    $error("facet_area exp %0d got %0d", w.facet_area, o_out.facet_area);
                    mismatches++;
                end
                if (o_out.normal_x !== w.normal_x) begin
                    $error("normal_x exp %0d got %0d", w.normal_x, o_out.normal_x);
                    mismatches++;
                end
                if (o_out.normal_y !== w.normal_y) begin
                    $error("normal_y exp %0d got %0d", w.normal_y, o_out.normal_y);
                    mismatches++;
                end
                if (o_out.normal_z !== w.normal_z) begin
                    $error("normal_z exp %0d got %0d", w.normal_z, o_out.normal_z);
                    mismatches++;
                end
                if (o_out.centroid_x !== w.centroid_x) begin
                    $error("centroid_x exp %0d got %0d", w.centroid_x, o_out.centroid_x);
                    mismatches++;
                end
                if (o_out.centroid_y !== w.centroid_y) begin
                    $error("centroid_y exp %0d got %0d", w.centroid_y, o_out.centroid_y);
                    mismatches++;
                end
                if (o_out.centroid_z !== w.centroid_z) begin
                    $error("centroid_z exp %0d got %0d", w.centroid_z, o_out.centroid_z);
                    mismatches++;
                end
                if (o_out.material_out !== w.material_out) begin
                    $error("material_out exp %0d got %0d", w.material_out,
                           o_out.material_out);
                    mismatches++;
                end
                if (o_out.degenerate !== w.degenerate) begin
                    $error("degenerate exp %0d got %0d", w.degenerate, o_out.degenerate);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_row             r;
        logic [TAG_W-1:0] tags[N_PHASES];
        int               per_phase;
        tags[0] = '0; tags[1] = 16'hFFFF; tags[2] = TAG_W'($urandom()); tags[3] = 16'h0001;
        per_phase = N_RANDOM / N_PHASES;

        // Directed rows; typed ones hold the answer at tag 0
        r.typed = 1'b1;
        r.tri_in = tri9(0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.want = flat(0, 16384, 0, 0, 0, 1); stash_row(r);
        r.tri_in = tri9(0, 0, 0, 4096, 0, 0, 0, 4096, 0);
        r.want = flat(2048, 16384, 1365, 1365, 0, 0); stash_row(r);
        r.tri_in = tri9(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                        8388607, 8388607, 8388607);
        r.want = flat(0, 16384, 8388607, 8388607, 8388607, 1); stash_row(r);
        r.tri_in = tri9(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                        -8388608, -8388608, -8388608);
        r.want = flat(0, 16384, -8388608, -8388608, -8388608, 1); stash_row(r);
        r.typed = 1'b0;
        r.want = '0;
        r.tri_in = tri9(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                        -8388608, 8388607, -8388608); stash_row(r);
        r.tri_in = tri9(-8388608, -8388608, -8388608, 8388607, 8388607, -8388608,
                        -8388608, 8388607, 8388607); stash_row(r);
        r.tri_in = tri9(8388607, -8388608, 0, -8388608, 8388607, 8388607,
                        0, 8388607, -8388608); stash_row(r);
        r.tri_in = tri9(0, 0, 0, 0, 4096, 0, 4096, 0, 0); stash_row(r);
        r.tri_in = tri9(0, 0, 0, 0, 0, 4096, 0, 4096, 0); stash_row(r);
        r.tri_in = tri9(1, 2, 3, 2, 4, 6, 3, 6, 9); stash_row(r);
        r.tri_in = tri9(0, 0, 0, 1, 0, 0, 0, 1, 0); stash_row(r);
        r.tri_in = tri9(-5, -5, -5, -4, -5, -5, -5, -4, -5); stash_row(r);
        r.tri_in = tri9(100, -200, 300, -400, 500, -600, 700, -800, 900); stash_row(r);
        r.tri_in = tri9(-1, -1, -1, -2, -1, -1, -1, -1, -2); stash_row(r);
        r.tri_in = tri9(8388607, 0, 0, 0, 8388607, 0, 0, 0, 8388607); stash_row(r);
        r.tri_in = tri9(-8388608, 0, 0, 0, -8388608, 0, 0, 0, -8388608); stash_row(r);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) send(rows[i].tri_in, rows[i].typed, rows[i].want,
                               i == rows.size() - 1);

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            // retag only with the pipe empty
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= tags[p];
            @(negedge i_clk);
            i_cfg_we    <= 1'b0;
            tag_now = tags[p];
            @(negedge i_clk);
            for (int i = 0; i < per_phase; i++) begin
                quiet = (p == 1) && (i >= 100) && (i < 350);
                send(random_facet(), 1'b0, '0, i == per_phase - 1);
            end
            quiet = 1'b0;
        end

        drain();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
